@@ hw/rtl/bqs_pkg.sv @@
// Package for the byte quantile selector.
// Holds the controller state type, register indexes and fixed field widths.
// No dependencies.
package bqs_pkg;

   localparam int unsigned SAMPLE_W = 8;
   localparam int unsigned BINS     = 256;
   localparam int unsigned RATIO_W  = 16;
   localparam int unsigned CSR_IDX_W = 1;

   localparam logic [CSR_IDX_W-1:0] CSR_RATIO_NUM = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_RATIO_DEN = 1'b1;

   localparam logic [RATIO_W-1:0] RATIO_NUM_RST = 16'd1;
   localparam logic [RATIO_W-1:0] RATIO_DEN_RST = 16'd2;

   typedef enum logic [2:0] {
      ST_CLR,
      ST_IDLE,
      ST_INC,
      ST_MUL,
      ST_DIV,
      ST_SCAN,
      ST_DONE
   } state_type;

endpackage

@@ hw/rtl/bqs_if.sv @@
// Channel interfaces of the byte quantile selector: sample input, result, csr write.
// Depends on bqs_pkg for field widths.
interface bqs_req_if;
   logic                          valid;
   logic                          ready;
   logic [bqs_pkg::SAMPLE_W-1:0]  sample;
   logic                          last;
   modport source (output valid, sample, last, input ready);
   modport sink   (input valid, sample, last, output ready);
endinterface

interface bqs_rsp_if;
   logic                          valid;
   logic                          ready;
   logic [bqs_pkg::SAMPLE_W-1:0]  quantile_value;
   logic                          overflow;
   modport source (output valid, quantile_value, overflow, input ready);
   modport sink   (input valid, quantile_value, overflow, output ready);
endinterface

interface bqs_csr_if;
   logic                          valid;
   logic                          ready;
   logic [bqs_pkg::CSR_IDX_W-1:0] idx;
   logic [bqs_pkg::RATIO_W-1:0]   wdata;
   modport source (output valid, idx, wdata, input ready);
   modport sink   (input valid, idx, wdata, output ready);
endinterface

@@ hw/rtl/bqs_ram.sv @@
// Generic simple dual-port RAM, one write and one registered read port.
// No dependencies.
module bqs_ram #(
   parameter int unsigned WIDTH = 8,
   parameter int unsigned DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic                     re,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

@@ hw/rtl/byte_quantile_select_top.sv @@
// Byte quantile selector. Samples of a set are tallied into a 256-bin histogram
// RAM; each beat reads its sample's bin, then writes it incremented (when the set
// is full, beats only flag overflow). The beat flagged last closes the set: n*num
// is formed, a restoring divider runs (skipped when num >= den or n is 0), and a
// scan of all 256 bins that also zeroes them follows; the result then goes into the
// output register once free. After reset a pass clears the RAM before any sample.
// Depends on bqs_pkg, bqs_if and bqs_ram.
module byte_quantile_select_top #(
   parameter int unsigned MAX_SAMPLES = 4096
) (
   input  logic           clock,
   input  logic           reset,
   bqs_req_if.sink        req_ch,
   bqs_rsp_if.source      rsp_ch,
   bqs_csr_if.sink        csr_ch
);

   localparam int unsigned CNT_W  = $clog2(MAX_SAMPLES + 1);
   localparam int unsigned PROD_W = CNT_W + bqs_pkg::RATIO_W;
   localparam int unsigned DIV_W  = $clog2(PROD_W + 1);
   localparam int unsigned BIN_AW = $clog2(bqs_pkg::BINS);
   localparam int unsigned SCAN_W = BIN_AW + 1;

   bqs_pkg::state_type state_ff, state_in;

   logic [bqs_pkg::RATIO_W-1:0] ratio_num_ff, ratio_den_ff;
   logic [CNT_W-1:0]            set_count_ff, set_count_in;
   logic                        overflowed_ff, overflowed_in;
   logic                        last_ff, last_in;
   logic [BIN_AW-1:0]           bin_ff, bin_in;
   logic [CNT_W-1:0]            k_ff, k_in;
   logic [bqs_pkg::RATIO_W:0]   rem_ff, rem_in;
   logic [PROD_W-1:0]           quo_ff, quo_in;
   logic [DIV_W-1:0]            div_ff, div_in;
   logic [SCAN_W-1:0]           scan_ff, scan_in;
   logic                        pend_ff, pend_in;
   logic [BIN_AW-1:0]           pend_addr_ff, pend_addr_in;
   logic [CNT_W-1:0]            seen_ff, seen_in;
   logic                        found_ff, found_in;
   logic [BIN_AW-1:0]           result_ff, result_in;
   logic                        rsp_valid_ff, rsp_valid_in;
   logic [bqs_pkg::SAMPLE_W-1:0] rsp_value_ff, rsp_value_in;
   logic                        rsp_ovf_ff, rsp_ovf_in;

   logic                        ram_we, ram_re;
   logic [BIN_AW-1:0]           ram_waddr, ram_raddr;
   logic [CNT_W-1:0]            ram_wdata, ram_rdata;

   logic                        req_fire, full, ratio_ge, div_done, scan_end, out_free;
   logic [PROD_W-1:0]           prod;
   logic [bqs_pkg::RATIO_W:0]   rem_sh, rem_diff;
   logic [CNT_W-1:0]            seen_sum;

   bqs_ram #(
      .WIDTH (CNT_W),
      .DEPTH (bqs_pkg::BINS)
   ) u_hist (
      .clock (clock),
      .we    (ram_we),
      .waddr (ram_waddr),
      .wdata (ram_wdata),
      .re    (ram_re),
      .raddr (ram_raddr),
      .rdata (ram_rdata)
   );

   assign req_ch.ready = (state_ff == bqs_pkg::ST_IDLE);
   assign csr_ch.ready = 1'b1;
   assign req_fire     = req_ch.valid && req_ch.ready;
   assign full         = (set_count_ff == CNT_W'(MAX_SAMPLES));
   assign ratio_ge     = (ratio_num_ff >= ratio_den_ff);
   assign prod         = PROD_W'(set_count_ff) * PROD_W'(ratio_num_ff);
   assign rem_sh       = {rem_ff[bqs_pkg::RATIO_W-1:0], quo_ff[PROD_W-1]};
   assign rem_diff     = rem_sh - {1'b0, ratio_den_ff};
   assign div_done     = (div_ff == '0);
   assign scan_end     = scan_ff[BIN_AW] && pend_ff;
   assign seen_sum     = seen_ff + ram_rdata;
   assign out_free     = !rsp_valid_ff || rsp_ch.ready;

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         bqs_pkg::ST_CLR: begin
            if (scan_ff[BIN_AW-1:0] == BIN_AW'(bqs_pkg::BINS - 1)) begin
               state_in = bqs_pkg::ST_IDLE;
            end
         end
         bqs_pkg::ST_IDLE: begin
            if (req_fire) begin
               if (!full) begin
                  state_in = bqs_pkg::ST_INC;
               end else if (req_ch.last) begin
                  state_in = bqs_pkg::ST_MUL;
               end
            end
         end
         bqs_pkg::ST_INC: begin
            state_in = last_ff ? bqs_pkg::ST_MUL : bqs_pkg::ST_IDLE;
         end
         bqs_pkg::ST_MUL: begin
            if (ratio_ge || set_count_ff == '0) begin
               state_in = bqs_pkg::ST_SCAN;
            end else begin
               state_in = bqs_pkg::ST_DIV;
            end
         end
         bqs_pkg::ST_DIV: begin
            if (div_done) begin
               state_in = bqs_pkg::ST_SCAN;
            end
         end
         bqs_pkg::ST_SCAN: begin
            if (scan_end) begin
               state_in = bqs_pkg::ST_DONE;
            end
         end
         bqs_pkg::ST_DONE: begin
            if (out_free) begin
               state_in = bqs_pkg::ST_IDLE;
            end
         end
         default: state_in = bqs_pkg::ST_CLR;
      endcase
   end

   // datapath and RAM control
   always_comb begin
      set_count_in  = set_count_ff;
      overflowed_in = overflowed_ff;
      last_in       = last_ff;
      bin_in        = bin_ff;
      k_in          = k_ff;
      rem_in        = rem_ff;
      quo_in        = quo_ff;
      div_in        = div_ff;
      scan_in       = scan_ff;
      pend_in       = 1'b0;
      pend_addr_in  = pend_addr_ff;
      seen_in       = seen_ff;
      found_in      = found_ff;
      result_in     = result_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ch.ready;
      rsp_value_in  = rsp_value_ff;
      rsp_ovf_in    = rsp_ovf_ff;
      ram_we        = 1'b0;
      ram_waddr     = bin_ff;
      ram_wdata     = '0;
      ram_re        = 1'b0;
      ram_raddr     = req_ch.sample;
      case (state_ff)
         bqs_pkg::ST_CLR: begin
            ram_we    = 1'b1;
            ram_waddr = scan_ff[BIN_AW-1:0];
            scan_in   = scan_ff + SCAN_W'(1);
         end
         bqs_pkg::ST_IDLE: begin
            if (req_fire) begin
               last_in = req_ch.last;
               bin_in  = req_ch.sample;
               if (full) begin
                  overflowed_in = 1'b1;
               end else begin
                  ram_re       = 1'b1;
                  set_count_in = set_count_ff + CNT_W'(1);
               end
            end
         end
         bqs_pkg::ST_INC: begin
            ram_we    = 1'b1;
            ram_wdata = ram_rdata + CNT_W'(1);
         end
         bqs_pkg::ST_MUL: begin
            if (set_count_ff == '0) begin
               k_in = '0;
            end else begin
               k_in = set_count_ff - CNT_W'(1);
            end
            rem_in   = '0;
            quo_in   = prod;
            div_in   = DIV_W'(PROD_W);
            scan_in  = '0;
            seen_in  = '0;
            found_in = 1'b0;
            result_in = '0;
         end
         bqs_pkg::ST_DIV: begin
            if (div_done) begin
               k_in = quo_ff[CNT_W-1:0];
            end else begin
               div_in = div_ff - DIV_W'(1);
               if (rem_sh >= {1'b0, ratio_den_ff}) begin
                  rem_in = rem_diff;
                  quo_in = {quo_ff[PROD_W-2:0], 1'b1};
               end else begin
                  rem_in = rem_sh;
                  quo_in = {quo_ff[PROD_W-2:0], 1'b0};
               end
            end
         end
         bqs_pkg::ST_SCAN: begin
            if (!scan_ff[BIN_AW]) begin
               ram_re       = 1'b1;
               ram_raddr    = scan_ff[BIN_AW-1:0];
               scan_in      = scan_ff + SCAN_W'(1);
               pend_in      = 1'b1;
               pend_addr_in = scan_ff[BIN_AW-1:0];
            end
            if (pend_ff) begin
               ram_we    = 1'b1;
               ram_waddr = pend_addr_ff;
               seen_in   = seen_sum;
               if (!found_ff && seen_sum > k_ff) begin
                  found_in  = 1'b1;
                  result_in = pend_addr_ff;
               end
            end
         end
         bqs_pkg::ST_DONE: begin
            if (out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_value_in  = result_ff;
               rsp_ovf_in    = overflowed_ff;
               set_count_in  = '0;
               overflowed_in = 1'b0;
            end
         end
         default: begin
            scan_in = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= bqs_pkg::ST_CLR;
         ratio_num_ff  <= bqs_pkg::RATIO_NUM_RST;
         ratio_den_ff  <= bqs_pkg::RATIO_DEN_RST;
         set_count_ff  <= '0;
         overflowed_ff <= 1'b0;
         scan_ff       <= '0;
         pend_ff       <= 1'b0;
         div_ff        <= '0;
         found_ff      <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         set_count_ff  <= set_count_in;
         overflowed_ff <= overflowed_in;
         scan_ff       <= scan_in;
         pend_ff       <= pend_in;
         div_ff        <= div_in;
         found_ff      <= found_in;
         rsp_valid_ff  <= rsp_valid_in;
         if (csr_ch.valid && csr_ch.ready) begin
            case (csr_ch.idx)
               bqs_pkg::CSR_RATIO_NUM: ratio_num_ff <= csr_ch.wdata;
               bqs_pkg::CSR_RATIO_DEN: ratio_den_ff <= csr_ch.wdata;
               default: ;
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      last_ff      <= last_in;
      bin_ff       <= bin_in;
      k_ff         <= k_in;
      rem_ff       <= rem_in;
      quo_ff       <= quo_in;
      pend_addr_ff <= pend_addr_in;
      seen_ff      <= seen_in;
      result_ff    <= result_in;
      rsp_value_ff <= rsp_value_in;
      rsp_ovf_ff   <= rsp_ovf_in;
   end

   assign rsp_ch.valid          = rsp_valid_ff;
   assign rsp_ch.quantile_value = rsp_value_ff;
   assign rsp_ch.overflow       = rsp_ovf_ff;

endmodule
